>>> design/iba_pkg.sv
// ----------------------------------------------------------------------------
// iba_pkg
// Shared types, sizes and codes of the inode block allocator.
// ----------------------------------------------------------------------------
package iba_pkg;

    localparam int NUM_INODES      = 16;
    localparam int NUM_BLOCKS      = 128;
    localparam int MAX_FILE_BLOCKS = 8;

    localparam int SLOT_W  = $clog2(NUM_INODES);
    localparam int BLOCK_W = $clog2(NUM_BLOCKS);
    localparam int PTR_W   = $clog2(MAX_FILE_BLOCKS);
    localparam int PADDR_W = SLOT_W + PTR_W;

    typedef enum logic [1:0]
    {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_MAP    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0]
    {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_NO_INODE  = 3'd2,
        ST_NO_BLOCKS = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_BAD_BLOCK = 3'd5,
        ST_TOO_LARGE = 3'd6
    } status_t;

    typedef struct packed
    {
        logic [1:0]  op;
        logic [63:0] file_name;
        logic [3:0]  file_blocks;
        logic [2:0]  block_number;
    } req_t;

    typedef struct packed
    {
        logic [2:0] status;
        logic [3:0] inode_slot;
        logic [6:0] disk_block;
    } rsp_t;

    // Zero every byte after the first zero byte.
    function automatic logic [63:0] trim_name(input logic [63:0] n);
        logic [63:0] r;
        logic        live;
        r    = '0;
        live = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (n[8*i +: 8] == 8'd0)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                r[8*i +: 8] = n[8*i +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] fold_name(input logic [63:0] n);
        logic [63:0] r;
        r = n;
        for (int i = 0; i < 8; i++)
        begin
            if (n[8*i +: 8] >= 8'h41 && n[8*i +: 8] <= 8'h5A)
            begin
                r[8*i +: 8] = n[8*i +: 8] + 8'h20;
            end
        end
        return r;
    endfunction

endpackage

>>> design/iba_if.sv
// ----------------------------------------------------------------------------
// iba_req_if / iba_rsp_if
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
interface iba_req_if;
    logic          valid;
    logic          ready;
    iba_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface iba_rsp_if;
    logic          valid;
    logic          ready;
    iba_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/inode_block_allocator.sv
// ----------------------------------------------------------------------------
// inode_block_allocator
// Inode table and free-block map; create, delete and map file operations.
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   op, file_name, file_blocks, block_number
//  rsp      out  valid/ready   status, inode_slot, disk_block
//
// One item at a time. Name lookup walks the 16 inodes one per cycle;
// create then seeks the first free inode the same way, walks the free map
// one block per cycle through its single read port, then writes the picks
// one per cycle. Delete reads each pointer, then frees its block; map
// reads the pointer in S_MAP_RD and takes it in S_MAP_WAIT.
// After reset a sweep clears the free map; req is held off.
// A waiting response holds the block until rsp is taken.
// ----------------------------------------------------------------------------
module inode_block_allocator
(
    input  logic       clk,
    input  logic       rst_n,
    iba_req_if.sink    req,
    iba_rsp_if.source  rsp
);
    import iba_pkg::*;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_FIND,
        S_FREE_SLOT,
        S_SCAN,
        S_COMMIT,
        S_DEL_RD,
        S_DEL_WR,
        S_MAP_RD,
        S_MAP_WAIT,
        S_RESP
    } state_t;

    state_t               state_reg;
    req_t                 req_reg;
    logic [63:0]          name_reg;
    logic [63:0]          key_reg;
    logic [SLOT_W:0]      idx_reg;
    logic [SLOT_W-1:0]    hit_slot_reg;
    logic [SLOT_W-1:0]    free_slot_reg;
    logic [BLOCK_W:0]     bidx_reg;
    logic [BLOCK_W-1:0]   picked_reg [MAX_FILE_BLOCKS];
    logic [PTR_W:0]       got_reg;
    logic                 scan_vld_reg;
    logic [BLOCK_W-1:0]   scan_addr_reg;
    rsp_t                 rsp_reg;

    logic                 used_reg  [NUM_INODES];
    logic [63:0]          sname_reg [NUM_INODES];
    logic [3:0]           slen_reg  [NUM_INODES];

    logic                 bm_rd;
    logic [BLOCK_W-1:0]   bm_rd_addr;
    logic                 bm_wr_en;
    logic [BLOCK_W-1:0]   bm_wr_addr;
    logic                 bm_wr_data;
    logic                 bm_ready;
    logic [PADDR_W-1:0]   pr_rd_addr;
    logic [BLOCK_W-1:0]   pr_rd;
    logic                 pr_wr_en;
    logic [PADDR_W-1:0]   pr_wr_addr;
    logic [BLOCK_W-1:0]   pr_wr_data;

    logic [SLOT_W-1:0]    cur;
    logic                 cur_match;
    logic [3:0]           want;

    assign cur       = idx_reg[SLOT_W-1:0];
    assign cur_match = used_reg[cur] && (fold_name(sname_reg[cur]) == key_reg);
    assign want      = req_reg.file_blocks;

    iba_bitmap u_bitmap
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (bm_rd_addr),
        .rd_data   (bm_rd),
        .wr_en     (bm_wr_en),
        .wr_addr   (bm_wr_addr),
        .wr_data   (bm_wr_data),
        .init_done (bm_ready)
    );

    iba_ptr_ram u_ptr
    (
        .clk     (clk),
        .rd_addr (pr_rd_addr),
        .rd_data (pr_rd),
        .wr_en   (pr_wr_en),
        .wr_addr (pr_wr_addr),
        .wr_data (pr_wr_data)
    );

    assign bm_rd_addr = bidx_reg[BLOCK_W-1:0];

    always_comb
    begin
        bm_wr_en   = 1'b0;
        bm_wr_addr = picked_reg[got_reg[PTR_W-1:0]];
        bm_wr_data = 1'b1;
        pr_wr_en   = 1'b0;
        pr_wr_addr = {free_slot_reg, got_reg[PTR_W-1:0]};
        pr_wr_data = picked_reg[got_reg[PTR_W-1:0]];
        pr_rd_addr = {hit_slot_reg, idx_reg[PTR_W-1:0]};
        unique case (state_reg)
            S_COMMIT:
            begin
                if (got_reg < want)
                begin
                    bm_wr_en = 1'b1;
                    pr_wr_en = 1'b1;
                end
            end
            S_DEL_WR:
            begin
                bm_wr_en   = (pr_rd != '0);
                bm_wr_addr = pr_rd;
                bm_wr_data = 1'b0;
            end
            S_MAP_RD:
            begin
                pr_rd_addr = {hit_slot_reg, req_reg.block_number[PTR_W-1:0]};
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready   = (state_reg == S_IDLE) && bm_ready;
    assign rsp.valid   = (state_reg == S_RESP);
    assign rsp.payload = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_vld_reg <= 1'b0;
            for (int i = 0; i < NUM_INODES; i++)
            begin
                used_reg[i] <= 1'b0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        req_reg  <= req.payload;
                        name_reg <= trim_name(req.payload.file_name);
                        key_reg  <= fold_name(trim_name(req.payload.file_name));
                        idx_reg  <= '0;
                        rsp_reg  <= '0;
                        if (req.payload.op == OP_NONE)
                        begin
                            state_reg <= S_RESP;
                        end
                        else if (req.payload.op == OP_CREATE &&
                                 req.payload.file_blocks > 4'(MAX_FILE_BLOCKS))
                        begin
                            rsp_reg.status <= ST_TOO_LARGE;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_FIND;
                        end
                    end
                end
                S_FIND:
                begin
                    if (cur_match)
                    begin
                        hit_slot_reg <= cur;
                        rsp_reg.inode_slot <= cur;
                        idx_reg      <= '0;
                        priority case (req_reg.op)
                            OP_CREATE:
                            begin
                                rsp_reg.status <= ST_DUP;
                                state_reg      <= S_RESP;
                            end
                            OP_DELETE: state_reg <= S_DEL_RD;
                            default:   state_reg <= S_MAP_RD;
                        endcase
                    end
                    else if (idx_reg == (SLOT_W+1)'(NUM_INODES - 1))
                    begin
                        idx_reg <= '0;
                        if (req_reg.op == OP_CREATE)
                        begin
                            state_reg <= S_FREE_SLOT;
                        end
                        else
                        begin
                            rsp_reg.status <= ST_NOT_FOUND;
                            state_reg      <= S_RESP;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_FREE_SLOT:
                begin
                    if (!used_reg[cur])
                    begin
                        free_slot_reg <= cur;
                        bidx_reg      <= '0;
                        got_reg       <= '0;
                        scan_vld_reg  <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                    else if (idx_reg == (SLOT_W+1)'(NUM_INODES - 1))
                    begin
                        rsp_reg.status <= ST_NO_INODE;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    // Memory read of bidx lands next cycle as bm_rd at scan_addr.
                    scan_addr_reg <= bm_rd_addr;
                    scan_vld_reg  <= !bidx_reg[BLOCK_W];
                    if (!bidx_reg[BLOCK_W])
                    begin
                        bidx_reg <= bidx_reg + 1'b1;
                    end
                    if ({1'b0, got_reg} >= {1'b0, want})
                    begin
                        got_reg   <= '0;
                        state_reg <= S_COMMIT;
                    end
                    else if (scan_vld_reg && !bm_rd)
                    begin
                        picked_reg[got_reg[PTR_W-1:0]] <= scan_addr_reg;
                        got_reg <= got_reg + 1'b1;
                        if ({1'b0, got_reg} + 5'd1 >= {1'b0, want})
                        begin
                            got_reg   <= '0;
                            state_reg <= S_COMMIT;
                        end
                    end
                    else if (!scan_vld_reg && bidx_reg[BLOCK_W])
                    begin
                        rsp_reg.status <= ST_NO_BLOCKS;
                        state_reg      <= S_RESP;
                    end
                end
                S_COMMIT:
                begin
                    if ({1'b0, got_reg} >= {1'b0, want})
                    begin
                        used_reg[free_slot_reg]  <= 1'b1;
                        sname_reg[free_slot_reg] <= name_reg;
                        slen_reg[free_slot_reg]  <= want;
                        rsp_reg.inode_slot       <= free_slot_reg;
                        state_reg                <= S_RESP;
                    end
                    else
                    begin
                        got_reg <= got_reg + 1'b1;
                    end
                end
                S_DEL_RD:
                begin
                    if ({1'b0, idx_reg} >= {1'b0, slen_reg[hit_slot_reg]})
                    begin
                        used_reg[hit_slot_reg] <= 1'b0;
                        state_reg              <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_DEL_WR;
                    end
                end
                S_DEL_WR:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_DEL_RD;
                end
                S_MAP_RD:
                begin
                    if ({1'b0, req_reg.block_number} >= slen_reg[hit_slot_reg])
                    begin
                        rsp_reg.status <= ST_BAD_BLOCK;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_MAP_WAIT;
                    end
                end
                S_MAP_WAIT:
                begin
                    rsp_reg.disk_block <= pr_rd;
                    state_reg          <= S_RESP;
                end
                S_RESP:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
    else $error("response changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !rsp.valid)
    else $error("request taken while response pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        bm_wr_en |-> (state_reg == S_COMMIT || state_reg == S_DEL_WR))
    else $error("free map written outside commit or delete");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.status != ST_OK |-> rsp.payload.disk_block == '0)
    else $error("disk block set on error");

endmodule

>>> design/iba_bitmap.sv
// ----------------------------------------------------------------------------
// iba_bitmap
// Free-block map in a synchronous memory with a registered read; a cleared
// sweep after reset marks block 0 used and the rest free.
// ----------------------------------------------------------------------------
module iba_bitmap
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [iba_pkg::BLOCK_W-1:0] rd_addr,
    output logic                        rd_data,
    input  logic                        wr_en,
    input  logic [iba_pkg::BLOCK_W-1:0] wr_addr,
    input  logic                        wr_data,
    output logic                        init_done
);
    import iba_pkg::*;

    logic                mem [NUM_BLOCKS];
    logic [BLOCK_W-1:0]  clr_reg;
    logic                done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (!done_reg)
        begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == BLOCK_W'(NUM_BLOCKS - 1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!done_reg)
        begin
            mem[clr_reg] <= (clr_reg == '0);
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign init_done = done_reg;

endmodule

>>> design/iba_ptr_ram.sv
// ----------------------------------------------------------------------------
// iba_ptr_ram
// Block pointer store, eight per inode, synchronous read.
// ----------------------------------------------------------------------------
module iba_ptr_ram
(
    input  logic                        clk,
    input  logic [iba_pkg::PADDR_W-1:0] rd_addr,
    output logic [iba_pkg::BLOCK_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [iba_pkg::PADDR_W-1:0] wr_addr,
    input  logic [iba_pkg::BLOCK_W-1:0] wr_data
);
    import iba_pkg::*;

    logic [BLOCK_W-1:0] mem [NUM_INODES*MAX_FILE_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> tb/inode_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inode_block_allocator_tb
// Drives create, delete and map items with random gaps and response stalls,
// predicts each response from a local copy of the inode table and free map,
// and compares every field of every response in order.
// ----------------------------------------------------------------------------
module inode_block_allocator_tb;

    import iba_pkg::*;

    localparam int RANDOM_ITEMS = 1130;
    localparam int CYCLE_LIMIT  = 4000000;

    typedef struct
    {
        op_t         op;
        logic [63:0] file_name;
        logic [3:0]  file_blocks;
        logic [2:0]  block_number;
        bit          fixed;
        rsp_t        answer;
    } row_t;

    logic clk;
    logic rst_n;

    iba_req_if req_ch ();
    iba_rsp_if rsp_ch ();

    inode_block_allocator dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    bit          blk_taken [NUM_BLOCKS];
    bit          ino_used  [NUM_INODES];
    logic [63:0] ino_name  [NUM_INODES];
    int          ino_len   [NUM_INODES];
    int          ino_ptr   [NUM_INODES][MAX_FILE_BLOCKS];

    rsp_t        pending_rsps[$];
    int          mismatches;
    int          cycles = 0;
    bit          stim_done;
    logic [63:0] name_pool[8];

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("inode_block_allocator_tb NOT OK");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic [63:0] clip_name(input logic [63:0] n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (n[8*i +: 8] == 8'd0)
            begin
                break;
            end
            r[8*i +: 8] = n[8*i +: 8];
        end
        return r;
    endfunction

    function automatic logic [63:0] lower_name(input logic [63:0] n);
        logic [63:0] r;
        logic [7:0]  b;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            b = n[8*i +: 8];
            if (b >= 8'h41 && b <= 8'h5A)
            begin
                b = b + 8'h20;
            end
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

    function automatic int lookup_inode(input logic [63:0] key);
        for (int i = 0; i < NUM_INODES; i++)
        begin
            if (ino_used[i] && lower_name(ino_name[i]) == key)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic rsp_t predict_fs_op(input op_t op, input logic [63:0] fname,
                                           input int want, input int bnum);
        rsp_t        r;
        logic [63:0] name;
        logic [63:0] key;
        int          s;
        int          fs;
        int          got;
        int          picks[MAX_FILE_BLOCKS];
        r    = '0;
        name = clip_name(fname);
        key  = lower_name(name);
        case (op)
            OP_CREATE:
            begin
                s = lookup_inode(key);
                if (want > MAX_FILE_BLOCKS)
                begin
                    r.status = ST_TOO_LARGE;
                end
                else if (s >= 0)
                begin
                    r.status     = ST_DUP;
                    r.inode_slot = 4'(s);
                end
                else
                begin
                    fs = -1;
                    for (int i = NUM_INODES - 1; i >= 0; i--)
                    begin
                        if (!ino_used[i])
                        begin
                            fs = i;
                        end
                    end
                    got = 0;
                    for (int i = 0; i < NUM_BLOCKS && got < want; i++)
                    begin
                        if (!blk_taken[i])
                        begin
                            picks[got] = i;
                            got++;
                        end
                    end
                    if (fs < 0)
                    begin
                        r.status = ST_NO_INODE;
                    end
                    else if (got < want)
                    begin
                        r.status = ST_NO_BLOCKS;
                    end
                    else
                    begin
                        ino_used[fs] = 1'b1;
                        ino_name[fs] = name;
                        ino_len[fs]  = want;
                        for (int k = 0; k < want; k++)
                        begin
                            ino_ptr[fs][k]      = picks[k];
                            blk_taken[picks[k]] = 1'b1;
                        end
                        r.inode_slot = 4'(fs);
                    end
                end
            end
            OP_DELETE:
            begin
                s = lookup_inode(key);
                if (s < 0)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    for (int k = 0; k < ino_len[s]; k++)
                    begin
                        if (ino_ptr[s][k] > 0)
                        begin
                            blk_taken[ino_ptr[s][k]] = 1'b0;
                        end
                    end
                    ino_used[s]  = 1'b0;
                    r.inode_slot = 4'(s);
                end
            end
            OP_MAP:
            begin
                s = lookup_inode(key);
                if (s < 0)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    r.inode_slot = 4'(s);
                    if (bnum >= ino_len[s])
                    begin
                        r.status = ST_BAD_BLOCK;
                    end
                    else
                    begin
                        r.disk_block = 7'(ino_ptr[s][bnum]);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic idle_gap();
        int n;
        n = 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: n = 0;
            4, 5, 6, 7: n = $urandom_range(1, 3);
            8:          n = $urandom_range(4, 12);
            default:    n = $urandom_range(20, 200);
        endcase
        if (n > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_item(input op_t op, input logic [63:0] fname,
                             input logic [3:0] nblk, input logic [2:0] bnum,
                             input bit fixed, input rsp_t answer);
        rsp_t guess;
        guess = predict_fs_op(op, fname, nblk, bnum);
        if (fixed && guess != answer)
        begin
            report("table row", guess, answer);
        end
        pending_rsps.push_back(fixed ? answer : guess);
        req_ch.valid                <= 1'b1;
        req_ch.payload.op           <= op;
        req_ch.payload.file_name    <= fname;
        req_ch.payload.file_blocks  <= nblk;
        req_ch.payload.block_number <= bnum;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [63:0] random_name();
        logic [63:0] n;
        logic [7:0]  b;
        int          len;
        n   = '0;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            b = $urandom_range(0, 1) ? 8'h61 + 8'($urandom_range(0, 3))
                                     : 8'h41 + 8'($urandom_range(0, 3));
            n[8*i +: 8] = b;
        end
        return n;
    endfunction

    function automatic logic [63:0] vary_name(input logic [63:0] n);
        logic [63:0] r;
        r = n;
        for (int i = 0; i < 8; i++)
        begin
            if (r[8*i +: 8] != 0 && $urandom_range(0, 1))
            begin
                r[8*i +: 8] = r[8*i +: 8] ^ 8'h20;
            end
        end
        if (r[63:56] == 8'd0 && $urandom_range(0, 3) == 0)
        begin
            r[63:56] = 8'($urandom);
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsps.size() == 0)
            begin
                report("unexpected item", rsp_ch.payload.status, -1);
            end
            else
            begin
                if (rsp_ch.payload.status != pending_rsps[0].status)
                    report("status", rsp_ch.payload.status, pending_rsps[0].status);
                if (rsp_ch.payload.inode_slot != pending_rsps[0].inode_slot)
                    report("inode_slot", rsp_ch.payload.inode_slot,
                           pending_rsps[0].inode_slot);
                if (rsp_ch.payload.disk_block != pending_rsps[0].disk_block)
                    report("disk_block", rsp_ch.payload.disk_block,
                           pending_rsps[0].disk_block);
                void'(pending_rsps.pop_front());
            end
        end
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stim_done || $urandom_range(0, 3) != 0)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 150)
                                                  : $urandom_range(1, 3))
                    @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        row_t        rows[$];
        row_t        r;
        op_t         op;
        logic [63:0] nm;
        int          pick;
        int          wait_cycles;

        mismatches   = 0;
        stim_done    = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            blk_taken[i] = (i == 0);
        end
        for (int i = 0; i < NUM_INODES; i++)
        begin
            ino_used[i] = 1'b0;
            ino_name[i] = '0;
            ino_len[i]  = 0;
        end

        rows = '{
            '{OP_MAP,    64'h0000_0000_0061_6261, 4'd0,  3'd0, 1'b1, '{ST_NOT_FOUND, 4'd0, 7'd0}},
            '{OP_DELETE, 64'h0000_0000_0061_6261, 4'd0,  3'd0, 1'b1, '{ST_NOT_FOUND, 4'd0, 7'd0}},
            '{OP_CREATE, 64'h0000_0000_0061_6261, 4'd15, 3'd0, 1'b1, '{ST_TOO_LARGE, 4'd0, 7'd0}},
            '{OP_CREATE, 64'h0000_0000_0061_6261, 4'd9,  3'd0, 1'b1, '{ST_TOO_LARGE, 4'd0, 7'd0}},
            '{OP_CREATE, 64'h0000_0000_0061_6261, 4'd8,  3'd0, 1'b1, '{ST_OK,        4'd0, 7'd0}},
            '{OP_MAP,    64'h0000_0000_0041_4241, 4'd0,  3'd0, 1'b1, '{ST_OK,        4'd0, 7'd1}},
            '{OP_MAP,    64'hFF00_0000_0061_6261, 4'd0,  3'd7, 1'b1, '{ST_OK,        4'd0, 7'd8}},
            '{OP_CREATE, 64'h0000_0000_0041_4241, 4'd1,  3'd0, 1'b1, '{ST_DUP,       4'd0, 7'd0}},
            '{OP_CREATE, 64'h0000_0000_0000_0000, 4'd0,  3'd0, 1'b1, '{ST_OK,        4'd1, 7'd0}},
            '{OP_MAP,    64'h1234_5678_9ABC_DE00, 4'd0,  3'd0, 1'b1, '{ST_BAD_BLOCK, 4'd1, 7'd0}},
            '{OP_CREATE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1,  3'd0, 1'b1, '{ST_OK,        4'd2, 7'd0}},
            '{OP_MAP,    64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  3'd1, 1'b1, '{ST_BAD_BLOCK, 4'd2, 7'd0}},
            '{OP_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 3'd7, 1'b1, '{ST_OK,        4'd0, 7'd0}},
            '{OP_DELETE, 64'h0000_0000_0061_6261, 4'd0,  3'd0, 1'b1, '{ST_OK,        4'd0, 7'd0}},
            '{OP_MAP,    64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  3'd0, 1'b0, '0},
            '{OP_CREATE, 64'h0000_0000_0000_0078, 4'd3,  3'd0, 1'b0, '0},
            '{OP_MAP,    64'h0000_0000_0000_0058, 4'd0,  3'd2, 1'b0, '0},
            '{OP_DELETE, 64'h0000_0000_0000_0000, 4'd0,  3'd0, 1'b0, '0},
            '{OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  3'd0, 1'b0, '0},
            '{OP_DELETE, 64'h0000_0000_0000_0078, 4'd0,  3'd0, 1'b0, '0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            r = rows[i];
            send_item(r.op, r.file_name, r.file_blocks, r.block_number, r.fixed, r.answer);
            idle_gap();
        end

        // fill inodes until the free map runs out, then overflow blocks
        for (int i = 0; i < NUM_INODES + 1; i++)
        begin
            nm = {56'd0, 8'h30 + i[7:0]};
            send_item(OP_CREATE, nm, 4'd8, 3'd0, 1'b0, '0);
        end
        for (int i = 0; i < NUM_INODES; i++)
        begin
            send_item(OP_DELETE, {56'd0, 8'h30 + i[7:0]}, 4'd0, 3'd0, 1'b0, '0);
        end

        for (int i = 0; i < 8; i++)
        begin
            name_pool[i] = random_name();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2 && pending_rsps.size() != 0)
            begin
                req_ch.valid <= 1'b0;
                while (pending_rsps.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            if ($urandom_range(0, 49) == 0)
            begin
                name_pool[$urandom_range(0, 7)] = random_name();
            end
            pick = $urandom_range(0, 99);
            nm   = pick < 90 ? vary_name(name_pool[$urandom_range(0, 7)])
                             : {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            op   = pick < 40 ? OP_CREATE : pick < 65 ? OP_DELETE :
                   pick < 97 ? OP_MAP : OP_NONE;
            send_item(op, nm,
                      4'($urandom_range(0, 9) == 0 ? $urandom_range(9, 15)
                                                   : $urandom_range(0, 8)),
                      3'($urandom_range(0, 7)), 1'b0, '0);
            if ($urandom_range(0, 2) == 0)
            begin
                idle_gap();
            end
        end

        stim_done = 1'b1;
        if (pending_rsps.size() != 0)
        begin
            req_ch.valid <= 1'b0;
            while (pending_rsps.size() != 0)
            begin
                @(posedge clk);
            end
        end
        wait_cycles = 200;
        repeat (wait_cycles) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("inode_block_allocator_tb OK");
        end
        else
        begin
            $display("inode_block_allocator_tb NOT OK");
        end
        $finish;
    end

endmodule
